// ===== rtl/spq_pkg.sv =====
// Shared constants, command and status codes, and cell control type.
package spq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int ID_BITS_DEF      = 16;
  localparam int PRIO_BITS        = 8;
  localparam int CMD_BITS         = 3;
  localparam int STATUS_BITS      = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_POP_HEAD = 3'd1,
    CMD_POP_GE   = 3'd2,
    CMD_POP_EQ   = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic                 go;
    logic                 full;
    cmd_t                 cmd;
    logic [PRIO_BITS-1:0] key;
  } ctl_t;

endpackage

// ===== rtl/spq_req_if.sv =====
// Command channel: valid/ready with command, priority or key, and payload.
interface spq_req_if #(
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::CMD_BITS-1:0]   cmd;
  logic [spq_pkg::PRIO_BITS-1:0]  prio_key;
  logic [PAYLOAD_BITS-1:0]        payload_in;

  modport source (output valid, cmd, prio_key, payload_in, input ready);
  modport sink   (input valid, cmd, prio_key, payload_in, output ready);
endinterface

// ===== rtl/spq_rsp_if.sv =====
// Result channel: valid/ready with status, priority, id and payload.
interface spq_rsp_if #(
  parameter int ID_BITS      = spq_pkg::ID_BITS_DEF,
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::STATUS_BITS-1:0] status;
  logic [spq_pkg::PRIO_BITS-1:0]   prio_out;
  logic [ID_BITS-1:0]              id_out;
  logic [PAYLOAD_BITS-1:0]         payload_out;

  modport source (output valid, status, prio_out, id_out, payload_out, input ready);
  modport sink   (input valid, status, prio_out, id_out, payload_out, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One queue slot: compares against the key, shifts right on insert, left on pop.
module spq_cell #(
  parameter int ID_BITS      = spq_pkg::ID_BITS_DEF,
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_pkg::ctl_t                 ctl,
  input  logic [ID_BITS-1:0]            new_id,
  input  logic [PAYLOAD_BITS-1:0]       new_payload,
  input  logic                          left_after,
  input  logic                          left_valid,
  input  logic [spq_pkg::PRIO_BITS-1:0] left_prio,
  input  logic [ID_BITS-1:0]            left_id,
  input  logic [PAYLOAD_BITS-1:0]       left_payload,
  input  logic                          right_valid,
  input  logic [spq_pkg::PRIO_BITS-1:0] right_prio,
  input  logic [ID_BITS-1:0]            right_id,
  input  logic [PAYLOAD_BITS-1:0]       right_payload,
  input  logic                          found_in,
  input  logic [spq_pkg::PRIO_BITS-1:0] hit_prio_in,
  input  logic [ID_BITS-1:0]            hit_id_in,
  input  logic [PAYLOAD_BITS-1:0]       hit_payload_in,
  output logic                          after,
  output logic                          valid,
  output logic [spq_pkg::PRIO_BITS-1:0] prio,
  output logic [ID_BITS-1:0]            id,
  output logic [PAYLOAD_BITS-1:0]       payload,
  output logic                          found_out,
  output logic [spq_pkg::PRIO_BITS-1:0] hit_prio_out,
  output logic [ID_BITS-1:0]            hit_id_out,
  output logic [PAYLOAD_BITS-1:0]       hit_payload_out
);

  logic match;

  assign after = !valid || (prio > ctl.key);

  always_comb begin
    case (ctl.cmd)
      spq_pkg::CMD_POP_HEAD: match = valid;
      spq_pkg::CMD_POP_GE:   match = valid && (prio >= ctl.key);
      spq_pkg::CMD_POP_EQ:   match = valid && (prio == ctl.key);
      default:               match = 1'b0;
    endcase
  end

  assign found_out       = found_in || match;
  assign hit_prio_out    = found_in ? hit_prio_in    : prio;
  assign hit_id_out      = found_in ? hit_id_in      : id;
  assign hit_payload_out = found_in ? hit_payload_in : payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.go) begin
      case (ctl.cmd)
        spq_pkg::CMD_INSERT: begin
          if (!ctl.full) begin
            if (left_after) begin
              valid <= left_valid;
            end else if (after) begin
              valid <= 1'b1;
            end
          end
        end
        spq_pkg::CMD_POP_HEAD, spq_pkg::CMD_POP_GE, spq_pkg::CMD_POP_EQ: begin
          if (found_out) begin
            valid <= right_valid;
          end
        end
        spq_pkg::CMD_CLEAR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.cmd)
        spq_pkg::CMD_INSERT: begin
          if (!ctl.full) begin
            if (left_after) begin
              prio    <= left_prio;
              id      <= left_id;
              payload <= left_payload;
            end else if (after) begin
              prio    <= ctl.key;
              id      <= new_id;
              payload <= new_payload;
            end
          end
        end
        spq_pkg::CMD_POP_HEAD, spq_pkg::CMD_POP_GE, spq_pkg::CMD_POP_EQ: begin
          if (found_out) begin
            prio    <= right_prio;
            id      <= right_id;
            payload <= right_payload;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue: a row of slot cells kept sorted, lowest priority at the head.
// The result beat appears in the cycle after the command beat and is held until taken.
// One command per cycle unless the single result register stays full; all cells update per beat.
// A new command is taken while the result register is empty or being emptied.
// Reset (rst, synchronous): all slots invalid, serial counter zero, no result pending.
module stable_priority_queue #(
  parameter int DEPTH        = spq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
  parameter int ID_BITS      = spq_pkg::ID_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int PB = spq_pkg::PRIO_BITS;

  logic                    accept;
  logic                    full;
  spq_pkg::ctl_t           ctl;
  spq_pkg::cmd_t           cmd;
  logic [ID_BITS-1:0]      next_serial;

  logic [DEPTH-1:0]        after_w;
  logic [DEPTH-1:0]        valid_w;
  logic [DEPTH-1:0]        found_w;
  logic [PB-1:0]           prio_w        [DEPTH];
  logic [ID_BITS-1:0]      id_w          [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_w     [DEPTH];
  logic [PB-1:0]           hit_prio_w    [DEPTH];
  logic [ID_BITS-1:0]      hit_id_w      [DEPTH];
  logic [PAYLOAD_BITS-1:0] hit_payload_w [DEPTH];

  logic [spq_pkg::STATUS_BITS-1:0] status_next;
  logic [PB-1:0]                   prio_next;
  logic [ID_BITS-1:0]              id_next;
  logic [PAYLOAD_BITS-1:0]         payload_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cmd       = spq_pkg::cmd_t'(req.cmd);
  assign full      = valid_w[DEPTH-1];

  assign ctl.go   = accept;
  assign ctl.full = full;
  assign ctl.cmd  = cmd;
  assign ctl.key  = req.prio_key;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    l_after;
    logic                    l_valid;
    logic [PB-1:0]           l_prio;
    logic [ID_BITS-1:0]      l_id;
    logic [PAYLOAD_BITS-1:0] l_payload;
    logic                    r_valid;
    logic [PB-1:0]           r_prio;
    logic [ID_BITS-1:0]      r_id;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic                    f_in;
    logic [PB-1:0]           h_prio;
    logic [ID_BITS-1:0]      h_id;
    logic [PAYLOAD_BITS-1:0] h_payload;

    if (i == 0) begin : g_head
      assign l_after   = 1'b0;
      assign l_valid   = 1'b0;
      assign l_prio    = '0;
      assign l_id      = '0;
      assign l_payload = '0;
      assign f_in      = 1'b0;
      assign h_prio    = '0;
      assign h_id      = '0;
      assign h_payload = '0;
    end else begin : g_mid
      assign l_after   = after_w[i-1];
      assign l_valid   = valid_w[i-1];
      assign l_prio    = prio_w[i-1];
      assign l_id      = id_w[i-1];
      assign l_payload = payload_w[i-1];
      assign f_in      = found_w[i-1];
      assign h_prio    = hit_prio_w[i-1];
      assign h_id      = hit_id_w[i-1];
      assign h_payload = hit_payload_w[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign r_valid   = 1'b0;
      assign r_prio    = '0;
      assign r_id      = '0;
      assign r_payload = '0;
    end else begin : g_body
      assign r_valid   = valid_w[i+1];
      assign r_prio    = prio_w[i+1];
      assign r_id      = id_w[i+1];
      assign r_payload = payload_w[i+1];
    end

    spq_cell #(
      .ID_BITS      (ID_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl),
      .new_id          (next_serial),
      .new_payload     (req.payload_in),
      .left_after      (l_after),
      .left_valid      (l_valid),
      .left_prio       (l_prio),
      .left_id         (l_id),
      .left_payload    (l_payload),
      .right_valid     (r_valid),
      .right_prio      (r_prio),
      .right_id        (r_id),
      .right_payload   (r_payload),
      .found_in        (f_in),
      .hit_prio_in     (h_prio),
      .hit_id_in       (h_id),
      .hit_payload_in  (h_payload),
      .after           (after_w[i]),
      .valid           (valid_w[i]),
      .prio            (prio_w[i]),
      .id              (id_w[i]),
      .payload         (payload_w[i]),
      .found_out       (found_w[i]),
      .hit_prio_out    (hit_prio_w[i]),
      .hit_id_out      (hit_id_w[i]),
      .hit_payload_out (hit_payload_w[i])
    );
  end

  always_comb begin
    status_next  = spq_pkg::ST_MISS;
    prio_next    = '0;
    id_next      = '0;
    payload_next = '0;
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        status_next  = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
        prio_next    = req.prio_key;
        id_next      = full ? '0 : next_serial;
        payload_next = req.payload_in;
      end
      spq_pkg::CMD_POP_HEAD, spq_pkg::CMD_POP_GE, spq_pkg::CMD_POP_EQ: begin
        if (found_w[DEPTH-1]) begin
          status_next  = spq_pkg::ST_DONE;
          prio_next    = hit_prio_w[DEPTH-1];
          id_next      = hit_id_w[DEPTH-1];
          payload_next = hit_payload_w[DEPTH-1];
        end
      end
      spq_pkg::CMD_CLEAR: status_next = spq_pkg::ST_DONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid   <= 1'b0;
      next_serial <= '0;
    end else begin
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (accept && cmd == spq_pkg::CMD_INSERT && !full) begin
        next_serial <= next_serial + ID_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.prio_out    <= prio_next;
      rsp.id_out      <= id_next;
      rsp.payload_out <= payload_next;
    end
  end

`ifndef SYNTHESIS
  // occupied slots always form a run from the head
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_w & (valid_w + DEPTH'(1))) == '0)
    else $error("slot valid bits not packed");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == spq_pkg::CMD_INSERT && full) |=> $stable(valid_w))
    else $error("insert into full queue changed occupancy");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == spq_pkg::CMD_INSERT && !full) |=>
      ($countones(valid_w) == $past($countones(valid_w)) + 1))
    else $error("insert did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && found_w[DEPTH-1] &&
     (cmd == spq_pkg::CMD_POP_HEAD || cmd == spq_pkg::CMD_POP_GE ||
      cmd == spq_pkg::CMD_POP_EQ)) |=>
      ($countones(valid_w) + 1 == $past($countones(valid_w))))
    else $error("pop did not remove one entry");
`endif

endmodule

// ===== bench/tb_stable_priority_queue.sv =====
// Testbench for stable_priority_queue: directed and random commands against a sorted-queue predictor.
`timescale 1ns / 1ps

module tb_stable_priority_queue;

  localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEF;
  localparam int PRIO_W      = spq_pkg::PRIO_BITS;
  localparam int CMD_W       = spq_pkg::CMD_BITS;
  localparam int ID_W        = spq_pkg::ID_BITS_DEF;
  localparam int PAY_W       = spq_pkg::PAYLOAD_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
  } slot_t;

  typedef struct packed {
    spq_pkg::status_t  status;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit idle_on = 1'b1;
  int err_count = 0;
  int unsigned cycle_count = 0;

  slot_t           model_slots[$];
  logic [ID_W-1:0] model_serial = '0;
  result_t         pending_results[$];
  result_t         want;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  stable_priority_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sorted queue: new entry goes before the first strictly greater priority
  function automatic result_t apply_queue_cmd(input logic [CMD_W-1:0] cmd,
                                              input logic [PRIO_W-1:0] key,
                                              input logic [PAY_W-1:0] payload);
    result_t r;
    slot_t   s;
    int      pos;
    int      i;
    bit      hit;
    r.status  = spq_pkg::ST_MISS;
    r.prio    = '0;
    r.id      = '0;
    r.payload = '0;
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        if (model_slots.size() >= QUEUE_DEPTH) begin
          r.status  = spq_pkg::ST_FULL;
          r.prio    = key;
          r.payload = payload;
        end else begin
          pos = model_slots.size();
          for (i = model_slots.size() - 1; i >= 0; i--)
            if (model_slots[i].prio > key) pos = i;
          s.prio    = key;
          s.id      = model_serial;
          s.payload = payload;
          model_slots.insert(pos, s);
          r.status  = spq_pkg::ST_DONE;
          r.prio    = key;
          r.id      = model_serial;
          r.payload = payload;
          model_serial++;
        end
      end
      spq_pkg::CMD_POP_HEAD, spq_pkg::CMD_POP_GE, spq_pkg::CMD_POP_EQ: begin
        pos = -1;
        for (i = model_slots.size() - 1; i >= 0; i--) begin
          hit = (cmd == spq_pkg::CMD_POP_HEAD) ||
                (cmd == spq_pkg::CMD_POP_GE && model_slots[i].prio >= key) ||
                (cmd == spq_pkg::CMD_POP_EQ && model_slots[i].prio == key);
          if (hit) pos = i;
        end
        if (pos >= 0) begin
          r.status  = spq_pkg::ST_DONE;
          r.prio    = model_slots[pos].prio;
          r.id      = model_slots[pos].id;
          r.payload = model_slots[pos].payload;
          model_slots.delete(pos);
        end
      end
      spq_pkg::CMD_CLEAR: begin
        model_slots.delete();
        r.status = spq_pkg::ST_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH %s: got %0h, wanted %0h at %0t", what, got, exp_val, $realtime);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(rsp_bus.status), '0);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(rsp_bus.status), 32'(want.status));
        check_field("prio_out", 32'(rsp_bus.prio_out), 32'(want.prio));
        check_field("id_out", 32'(rsp_bus.id_out), 32'(want.id));
        check_field("payload_out", rsp_bus.payload_out, want.payload);
      end
    end
  end

  // result-side back-pressure
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] key,
                          input logic [PAY_W-1:0] payload);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= cmd;
    req_bus.prio_key   <= key;
    req_bus.payload_in <= payload;
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(apply_queue_cmd(cmd, key, payload));
  endtask

  task automatic wait_results_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0:       return PRIO_W'($urandom_range(0, 255));
      1:       return PRIO_W'($urandom_range(0, 7));
      2:       return PRIO_W'($urandom_range(250, 255));
      default: return PRIO_W'($urandom_range(100, 103));
    endcase
  endfunction

  task automatic test_empty_and_spare();
    int c;
    send_cmd(spq_pkg::CMD_POP_HEAD, 8'd0, 32'hFFFF_FFFF);
    send_cmd(spq_pkg::CMD_POP_GE, 8'd0, 32'h0);
    send_cmd(spq_pkg::CMD_POP_EQ, 8'd255, 32'h0);
    for (c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send_cmd(CMD_W'(c), 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_ordering();
    send_cmd(spq_pkg::CMD_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_cmd(spq_pkg::CMD_INSERT, 8'd0, 32'h0000_0000);
    send_cmd(spq_pkg::CMD_INSERT, 8'd255, 32'h0000_0001);
    send_cmd(spq_pkg::CMD_INSERT, 8'd128, 32'hA5A5_A5A5);
    send_cmd(spq_pkg::CMD_INSERT, 8'd0, 32'h5A5A_5A5A);
    send_cmd(spq_pkg::CMD_POP_EQ, 8'd255, 32'h0);
    send_cmd(spq_pkg::CMD_POP_GE, 8'd200, 32'h0);
    send_cmd(spq_pkg::CMD_POP_EQ, 8'd7, 32'h0);
    send_cmd(spq_pkg::CMD_POP_GE, 8'd0, 32'h0);
    send_cmd(spq_pkg::CMD_POP_HEAD, 8'd0, 32'h0);
    send_cmd(spq_pkg::CMD_POP_GE, 8'd129, 32'h0);
    send_cmd(spq_pkg::CMD_POP_EQ, 8'd128, 32'h0);
    send_cmd(spq_pkg::CMD_INSERT, 8'd7, 32'h1234_5678);
    send_cmd(spq_pkg::CMD_CLEAR, 8'd0, 32'hFFFF_FFFF);
    send_cmd(spq_pkg::CMD_POP_HEAD, 8'd0, 32'h0);
  endtask

  task automatic test_fill_overflow();
    int n;
    for (n = 0; n < QUEUE_DEPTH; n++)
      send_cmd(spq_pkg::CMD_INSERT, rand_prio(), $urandom);
    send_cmd(spq_pkg::CMD_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_cmd(spq_pkg::CMD_INSERT, 8'd0, 32'h0);
    send_cmd(spq_pkg::CMD_POP_EQ, model_slots[$urandom_range(0, QUEUE_DEPTH - 1)].prio, 32'h0);
    send_cmd(spq_pkg::CMD_INSERT, 8'd1, 32'h8000_0001);
    send_cmd(spq_pkg::CMD_INSERT, 8'd2, 32'h7FFF_FFFE);
    send_cmd(spq_pkg::CMD_CLEAR, 8'd0, 32'h0);
  endtask

  // back-to-back rounds of inserts to one short of full, then a clear; serials keep counting across clears
  task automatic test_fill_clear_rounds();
    int w;
    int n;
    idle_on = 1'b0;
    for (w = 0; w < 8; w++) begin
      for (n = 0; n < QUEUE_DEPTH - 1; n++)
        send_cmd(spq_pkg::CMD_INSERT, rand_prio(), $urandom);
      send_cmd(spq_pkg::CMD_CLEAR, PRIO_W'($urandom_range(0, 255)), $urandom);
    end
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  task automatic random_traffic(input int count, input int insert_pct);
    int n;
    int pick;
    logic [PRIO_W-1:0] key;
    for (n = 0; n < count; n++) begin
      if (model_slots.size() != 0 && $urandom_range(0, 3) != 0)
        key = model_slots[$urandom_range(0, model_slots.size() - 1)].prio;
      else
        key = rand_prio();
      if ($urandom_range(0, 99) < insert_pct) begin
        send_cmd(spq_pkg::CMD_INSERT, rand_prio(), $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30)
          send_cmd(spq_pkg::CMD_POP_HEAD, PRIO_W'($urandom_range(0, 255)), $urandom);
        else if (pick < 62)
          send_cmd(spq_pkg::CMD_POP_GE, key, $urandom);
        else if (pick < 95)
          send_cmd(spq_pkg::CMD_POP_EQ, key, $urandom);
        else if (pick < 97)
          send_cmd(spq_pkg::CMD_CLEAR, PRIO_W'($urandom_range(0, 255)), $urandom);
        else
          send_cmd(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                   PRIO_W'($urandom_range(0, 255)), $urandom);
      end
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    random_traffic(400, 70);
    random_traffic(400, 30);
    random_traffic(350, 50);
    idle_on = 1'b0;
    random_traffic(350, 55);
  endtask

  initial begin
    req_bus.valid      <= 1'b0;
    req_bus.cmd        <= spq_pkg::CMD_INSERT;
    req_bus.prio_key   <= '0;
    req_bus.payload_in <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_spare();
    test_ordering();
    test_fill_overflow();
    test_fill_clear_rounds();
    test_random_traffic();

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
